// ----- rtl/fdl_pkg.sv -----
// Shared widths, constants, types and helpers of the feedback delay line.
`default_nettype none

package fdl_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int CH_W       = 1;
  localparam int CHANNELS   = 2**CH_W;
  localparam int PTR_W      = 16;
  localparam int ADDR_W     = CH_W + PTR_W;
  localparam int DEPTH      = 2**ADDR_W;
  localparam int GAIN_W     = 16;
  localparam int MIX_W      = 17;
  localparam int FRAC_W     = 16;
  localparam int FB_PROD_W  = SAMPLE_W + GAIN_W + 1;
  localparam int FB_VAL_W   = FB_PROD_W - FRAC_W;
  localparam int MIX_PROD_W = SAMPLE_W + MIX_W + 1;
  localparam int ACC_W      = MIX_PROD_W + 1;
  localparam int SUM_W      = ACC_W - FRAC_W;
  localparam int HALF_LSB   = 2**(FRAC_W - 1);
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [MIX_W-1:0]  MIX_UNITY   = MIX_W'(2**FRAC_W);
  localparam logic [MIX_W-1:0]  WET_RESET   = MIX_W'(HALF_LSB);
  localparam logic [PTR_W-1:0]  DELAY_RESET = PTR_W'(1);
  localparam logic [GAIN_W-1:0] FB_RESET    = '0;

  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2**(SAMPLE_W - 1) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(2**(SAMPLE_W - 1)));

  typedef enum logic [1:0] {
    REG_DELAY    = 2'd0,
    REG_FEEDBACK = 2'd1,
    REG_WET      = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [PTR_W-1:0]  delay;
    logic [GAIN_W-1:0] fb_gain;
    logic [MIX_W-1:0]  wet_gain;
    logic [MIX_W-1:0]  dry_gain;
  } cfg_t;

  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [SUM_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SAMPLE_W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SAMPLE_W-1:0];
    end else begin
      r = v[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fdl_regs.sv -----
// APB configuration registers of the feedback delay line.
`default_nettype none

module fdl_regs import fdl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output cfg_t                  cfg
);

  logic [PTR_W-1:0]  delay_samples;
  logic [GAIN_W-1:0] feedback_gain;
  logic [MIX_W-1:0]  wet_mix;
  logic [MIX_W-1:0]  wet_gain;
  logic [MIX_W-1:0]  dry_gain;
  logic [MIX_W-1:0]  wet_in;
  logic [MIX_W-1:0]  wet_clamped;
  reg_idx_t          idx;
  logic              wr_en;

  assign idx         = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en       = psel && penable && pwrite;
  assign wet_in      = pwdata[MIX_W-1:0];
  assign wet_clamped = (wet_in > MIX_UNITY) ? MIX_UNITY : wet_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= DELAY_RESET;
      feedback_gain <= FB_RESET;
      wet_mix       <= WET_RESET;
      wet_gain      <= WET_RESET;
      dry_gain      <= MIX_UNITY - WET_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_DELAY: begin
          delay_samples <= pwdata[PTR_W-1:0];
        end
        REG_FEEDBACK: begin
          feedback_gain <= pwdata[GAIN_W-1:0];
        end
        REG_WET: begin
          wet_mix  <= wet_in;
          wet_gain <= wet_clamped;
          dry_gain <= MIX_UNITY - wet_clamped;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_DELAY:    prdata = APB_DATA_W'(delay_samples);
      REG_FEEDBACK: prdata = APB_DATA_W'(feedback_gain);
      REG_WET:      prdata = APB_DATA_W'(wet_mix);
      default:      prdata = '0;
    endcase
  end

  assign cfg = '{delay: delay_samples, fb_gain: feedback_gain,
                 wet_gain: wet_gain, dry_gain: dry_gain};

endmodule

`default_nettype wire

// ----- rtl/feedback_delay_line_unit.sv -----
// Top level of the two-channel feedback delay line with dry/wet mix.
// The block takes one sample beat per cycle when not stalled; each beat is registered
// at the tap read, the products and the output. The one exception is a sample that
// follows one of the same channel directly while the delay is one: it waits for the
// previous sample's write-back, as its tap is the entry that sample is still writing
// in the read-modify-write loop through the delay memory (read, multiply, add and
// saturate, write back). The memory holds 65536 entries per channel and is not
// cleared by a sweep: a per-channel fill mark makes entries not yet written since
// reset read as zero, so input is taken at once. Delay zero means a full buffer.
`default_nettype none

module feedback_delay_line_unit import fdl_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [APB_ADDR_W-1:0]      paddr,
  input  logic [APB_DATA_W-1:0]      pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_in,
  input  logic [CH_W-1:0]            channel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] sample_out,
  output logic [CH_W-1:0]            channel_out
);

  cfg_t cfg;

  logic [PTR_W-1:0]    wr_ptr [CHANNELS];
  logic [CHANNELS-1:0] wrapped;

  logic [PTR_W-1:0] in_wp;
  logic [PTR_W-1:0] in_tap;
  logic             in_tap_written;
  logic             hazard;
  logic             in_fire;

  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_x;
  logic [CH_W-1:0]            s1_ch;
  logic [PTR_W-1:0]           s1_wp;
  logic [PTR_W-1:0]           s1_tap;
  logic                       s1_tap_written;
  logic                       s1_ready;
  logic                       s1_fire;

  logic [SAMPLE_W-1:0]        mem [DEPTH];
  logic [SAMPLE_W-1:0]        rdata;
  logic                       cap_valid;
  logic [ADDR_W-1:0]          cap_addr;
  logic [SAMPLE_W-1:0]        cap_data;
  logic signed [SAMPLE_W-1:0] delayed;

  logic                         s2_valid;
  logic signed [SAMPLE_W-1:0]   s2_x;
  logic [CH_W-1:0]              s2_ch;
  logic [PTR_W-1:0]             s2_wp;
  logic signed [FB_PROD_W-1:0]  s2_fb_prod;
  logic signed [MIX_PROD_W-1:0] s2_dry_prod;
  logic signed [MIX_PROD_W-1:0] s2_wet_prod;
  logic                         s2_ready;
  logic                         s2_fire;
  logic                         out_ok;

  logic signed [FB_PROD_W-1:0]  fb_acc;
  logic signed [FB_PROD_W-1:0]  fb_shift;
  logic signed [FB_VAL_W-1:0]   fb_val;
  logic signed [SUM_W-1:0]      store_sum;
  logic signed [ACC_W-1:0]      mix_acc;
  logic signed [ACC_W-1:0]      mix_shift;
  logic signed [SUM_W-1:0]      mix_sum;
  logic signed [SAMPLE_W-1:0]   store_value;
  logic signed [SAMPLE_W-1:0]   mix_value;

  fdl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  // Accept side: tap address, fill check and interlock against pending writes.
  assign in_wp          = wr_ptr[channel];
  assign in_tap         = in_wp - cfg.delay;
  assign in_tap_written = wrapped[channel] || (in_tap < in_wp);
  assign hazard = (s1_valid && (s1_ch == channel) && (s1_wp == in_tap)) ||
                  (s2_valid && !s2_fire && (s2_ch == channel) && (s2_wp == in_tap));

  assign out_ok   = !out_valid || out_ready;
  assign s2_ready = !s2_valid || out_ok;
  assign s2_fire  = s2_valid && out_ok;
  assign s1_ready = !s1_valid || s2_ready;
  assign s1_fire  = s1_valid && s2_ready;
  assign in_ready = s1_ready && !hazard;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        wr_ptr[i] <= '0;
      end
      wrapped <= '0;
    end else if (in_fire) begin
      wr_ptr[channel] <= in_wp + 1'b1;
      if (in_wp == '1) begin
        wrapped[channel] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      mem[{s2_ch, s2_wp}] <= store_value;
    end
    if (in_fire) begin
      rdata <= mem[{channel, in_tap}];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_valid <= 1'b0;
    end else if (s2_fire) begin
      cap_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      cap_addr <= {s2_ch, s2_wp};
      cap_data <= store_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x           <= sample_in;
      s1_ch          <= channel;
      s1_wp          <= in_wp;
      s1_tap         <= in_tap;
      s1_tap_written <= in_tap_written;
    end
  end

  // The most recent write covers a write-back that lands at the read edge.
  always_comb begin
    if (cap_valid && (cap_addr == {s1_ch, s1_tap})) begin
      delayed = $signed(cap_data);
    end else if (s1_tap_written) begin
      delayed = $signed(rdata);
    end else begin
      delayed = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_x        <= s1_x;
      s2_ch       <= s1_ch;
      s2_wp       <= s1_wp;
      s2_fb_prod  <= FB_PROD_W'(delayed) * FB_PROD_W'($signed({1'b0, cfg.fb_gain}));
      s2_dry_prod <= MIX_PROD_W'($signed({1'b0, cfg.dry_gain})) * MIX_PROD_W'(s1_x);
      s2_wet_prod <= MIX_PROD_W'($signed({1'b0, cfg.wet_gain})) * MIX_PROD_W'(delayed);
    end
  end

  always_comb begin
    fb_acc      = s2_fb_prod + $signed(FB_PROD_W'(HALF_LSB));
    fb_shift    = fb_acc >>> FRAC_W;
    fb_val      = fb_shift[FB_VAL_W-1:0];
    store_sum   = SUM_W'(s2_x) + SUM_W'(fb_val);
    store_value = sat_sample(store_sum);
    mix_acc     = ACC_W'(s2_dry_prod) + ACC_W'(s2_wet_prod) + $signed(ACC_W'(HALF_LSB));
    mix_shift   = mix_acc >>> FRAC_W;
    mix_sum     = mix_shift[SUM_W-1:0];
    mix_value   = sat_sample(mix_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      sample_out  <= mix_value;
      channel_out <= s2_ch;
    end
  end

`ifndef ASSERT_OFF
  a_no_pending_tap: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_valid && (s1_ch == s2_ch) |-> (s1_tap != s2_wp))
    else $error("tap of stage 1 is still being written by stage 2");

  a_rdata_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_ready |=> s1_valid && $stable(rdata))
    else $error("read data changed while stage 1 stalled");

  a_ptr_advance: assert property (@(posedge clk) disable iff (rst)
    in_fire && (channel == 1'b0) |=> (wr_ptr[0] == $past(wr_ptr[0]) + 1'b1))
    else $error("write pointer of channel 0 did not advance by one");

  a_ptr_hold: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable({wr_ptr[1], wr_ptr[0]}))
    else $error("write pointer moved without an accepted beat");
`endif

endmodule

`default_nettype wire
